>>> rtl/megd_pkg.sv
package megd_pkg;

	localparam int TIME_BITS = 32;
	localparam int GUARD_STEP_MS = 20;
	localparam logic [7:0] ESC_MAX = 8'd127;
	localparam logic [1:0] HELD_FULL = 2'd3;
	localparam logic OP_TICK = 1'b1;
	localparam int GUARD_BITS = 13;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_COUNT = 2'd1,
		PH_TRAIL = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] escape_char;
		logic [7:0] guard_mult;
	} cfg_t;

	// Outcome of one item: released held characters, then the optional forwarded byte.
	typedef struct packed {
		logic [1:0] rel;
		logic       fwd;
		logic [7:0] fwd_byte;
		logic [7:0] esc_byte;
		logic       esc;
	} desc_t;

endpackage

>>> rtl/megd_if.sv
interface megd_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [7:0]  in_byte;
	logic [31:0] now_ms;

	modport source (output valid, op, in_byte, now_ms, input ready);
	modport sink (input valid, op, in_byte, now_ms, output ready);
endinterface

interface megd_out_if;
	logic       valid;
	logic       ready;
	logic       has_byte;
	logic [7:0] out_byte;
	logic       escaped;
	logic       last;

	modport source (output valid, has_byte, out_byte, escaped, last, input ready);
	modport sink (input valid, has_byte, out_byte, escaped, last, output ready);
endinterface

>>> rtl/megd_cfg.sv
module megd_cfg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [2:0]      paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output megd_pkg::cfg_t  cfg
);
	import megd_pkg::*;

	logic [7:0] escape_char_q;
	logic [7:0] guard_mult_q;
	logic       wr;

	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_char_q <= 8'd43;
			guard_mult_q <= 8'd50;
		end else if (wr) begin
			if (paddr[2]) begin
				guard_mult_q <= pwdata[7:0];
			end else begin
				escape_char_q <= pwdata[7:0];
			end
		end
	end

	assign prdata = paddr[2] ? {24'd0, guard_mult_q} : {24'd0, escape_char_q};
	assign cfg.escape_char = escape_char_q;
	assign cfg.guard_mult = guard_mult_q;
endmodule

>>> rtl/megd_core.sv
module megd_core (
	input  logic            clk,
	input  logic            arst_n,
	megd_in_if.sink         data_ch,
	input  megd_pkg::cfg_t  cfg,
	input  logic            take,
	output megd_pkg::desc_t desc,
	output logic            desc_valid
);
	import megd_pkg::*;

	logic                 valid_s1;
	logic                 op_s1;
	logic [7:0]           byte_s1;
	logic [31:0]          now_s1;

	phase_t               phase_q, phase_d;
	logic [1:0]           held_q, held_d;
	logic [TIME_BITS-1:0] time_q, time_d;
	logic                 seen_q, seen_d;

	logic                 advance;
	logic [TIME_BITS-1:0] now_w;
	logic [TIME_BITS-1:0] diff;
	logic [GUARD_BITS-1:0] guard;
	logic                 gap_ok;
	logic [1:0]           rel;
	logic                 fwd;
	logic                 esc;
	phase_t               ph;
	logic [1:0]           hc;

	assign advance = valid_s1 && take;
	assign data_ch.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ch.valid && data_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (data_ch.valid && data_ch.ready) begin
			op_s1 <= data_ch.op;
			byte_s1 <= data_ch.in_byte;
			now_s1 <= data_ch.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q <= 2'd0;
			time_q <= '0;
			seen_q <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			held_q <= held_d;
			time_q <= time_d;
			seen_q <= seen_d;
		end
	end

	always_comb begin
		now_w = TIME_BITS'(now_s1);
		diff = now_w - time_q;
		guard = GUARD_BITS'(cfg.guard_mult) * GUARD_BITS'(GUARD_STEP_MS);
		// Before the first byte the silence counts as a full guard time.
		gap_ok = !seen_q || (diff >= TIME_BITS'(guard));
		phase_d = phase_q;
		held_d = held_q;
		time_d = time_q;
		seen_d = seen_q;
		rel = 2'd0;
		fwd = 1'b0;
		esc = 1'b0;
		ph = phase_q;
		hc = held_q;
		if (op_s1 == OP_TICK) begin
			if (phase_q != PH_IDLE && seen_q && gap_ok) begin
				if (phase_q == PH_TRAIL) begin
					esc = 1'b1;
				end else begin
					rel = held_q;
				end
				phase_d = PH_IDLE;
				held_d = 2'd0;
			end
		end else begin
			time_d = now_w;
			seen_d = 1'b1;
			if (cfg.escape_char > ESC_MAX) begin
				fwd = 1'b1;
			end else if (phase_q == PH_TRAIL && gap_ok) begin
				// Trailing guard elapsed: the escape wins and this byte is dropped.
				esc = 1'b1;
				phase_d = PH_IDLE;
				held_d = 2'd0;
			end else begin
				if (ph != PH_IDLE && gap_ok) begin
					rel = hc;
					hc = 2'd0;
					ph = PH_IDLE;
				end
				if (byte_s1 == cfg.escape_char) begin
					unique case (ph)
						PH_COUNT: begin
							hc = 2'(hc + 2'd1);
							if (hc == HELD_FULL) begin
								ph = PH_TRAIL;
							end
						end
						PH_TRAIL: begin
							rel = hc;
							hc = 2'd0;
							ph = PH_IDLE;
							fwd = 1'b1;
						end
						PH_IDLE: begin
							if (gap_ok) begin
								hc = 2'd1;
								ph = PH_COUNT;
							end else begin
								fwd = 1'b1;
							end
						end
					endcase
				end else begin
					if (ph != PH_IDLE) begin
						rel = hc;
						hc = 2'd0;
						ph = PH_IDLE;
					end
					fwd = 1'b1;
				end
				phase_d = ph;
				held_d = hc;
			end
		end
	end

	assign desc.rel = rel;
	assign desc.fwd = fwd;
	assign desc.fwd_byte = byte_s1;
	assign desc.esc_byte = cfg.escape_char;
	assign desc.esc = esc;
	assign desc_valid = valid_s1;
endmodule

>>> rtl/megd_emit.sv
module megd_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  megd_pkg::desc_t desc,
	input  logic            desc_valid,
	output logic            take,
	megd_out_if.source      result_ch
);
	import megd_pkg::*;

	desc_t      desc_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic [2:0] total;
	logic       is_rel;
	logic       last;

	assign total = {1'b0, desc_s2.rel} + {2'b00, desc_s2.fwd};
	assign is_rel = idx_q < desc_s2.rel;
	assign last = (total == 3'd0) || ({1'b0, idx_q} == 3'(total - 3'd1));
	assign take = !valid_s2 || (result_ch.ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= 2'd0;
		end else if (take) begin
			valid_s2 <= desc_valid;
			idx_q <= 2'd0;
		end else if (result_ch.ready) begin
			idx_q <= 2'(idx_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			desc_s2 <= desc;
		end
	end

	assign result_ch.valid = valid_s2;
	assign result_ch.has_byte = (total != 3'd0);
	assign result_ch.out_byte = is_rel ? desc_s2.esc_byte :
		(desc_s2.fwd ? desc_s2.fwd_byte : 8'd0);
	assign result_ch.escaped = desc_s2.esc && last;
	assign result_ch.last = last;
endmodule

>>> rtl/modem_escape_guard_detector.sv
// Escape guard-time detector for a modem data path.
// Items enter on data_ch: op selects a data byte or a timer tick, and now_ms
// stamps it. Results leave on result_ch, one per forwarded byte, or one empty
// result when nothing is forwarded; last marks the final result of an item and
// escaped on that result reports a recognized escape sequence.
// Up to three escape characters are held back; when the candidate fails they
// are released ahead of the current byte, so an item yields one to four results.
// The escape character and guard time are written through the APB port
// (offset 0 and 4); they should only change while the block is idle.
// An item passes the input register, then the output stage register, before
// its first result is offered. Throughput: one result per cycle from the output
// stage while result_ch.ready is high; the next item enters it only once the
// last result of the current one is taken. The decision logic takes a new item
// every cycle while the output stage takes its descriptors.
// Reset clears the state and restores the escape character to '+' and the guard
// to one second. When result_ch stalls, the output stage holds its result and
// one more item waits in the input register before data_ch.ready drops.
module modem_escape_guard_detector (
	input  logic        clk,
	input  logic        arst_n,
	megd_in_if.sink     data_ch,
	megd_out_if.source  result_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import megd_pkg::*;

	cfg_t  cfg;
	desc_t desc;
	logic  desc_valid;
	logic  take;

	megd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	megd_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_ch    (data_ch),
		.cfg        (cfg),
		.take       (take),
		.desc       (desc),
		.desc_valid (desc_valid)
	);

	megd_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.desc       (desc),
		.desc_valid (desc_valid),
		.take       (take),
		.result_ch  (result_ch)
	);
endmodule
